>>> hw/rtl/swk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swerve kinematics package
// Shared widths, constants, the arctangent table and the beat type that
// travels down the CORDIC cell chain.
// ----------------------------------------------------------------------------
package swk_pkg;

    localparam int POS_W            = 16;
    localparam int POD_W            = 2;
    localparam int CFG_IDX_W        = 3;
    localparam int NUM_PODS_DEF     = 4;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_STEPS      = 24;

    // Vectors enter the chain scaled by 256; 27 bits cover the CORDIC gain.
    localparam int XY_W       = 27;
    localparam int GUARD_BITS = 8;
    localparam int ANG_W      = 32;

    // Register index decode: bit 0 picks the axis, the upper bits the pod.
    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // Inverse CORDIC gain, Q0.32, and the shift that brings the product to Q8.8.
    localparam logic [31:0] INV_GAIN  = 32'h9B74_EDA8;
    localparam int          MAG_SHIFT = 40;

    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

    localparam logic [ANG_W-1:0] ATAN_TAB [TABLE_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic                    valid;
        logic                    zero;
        logic                    last;
        logic [POD_W-1:0]        pod;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic [ANG_W-1:0]        z;
    } t_cell_beat;

endpackage
`default_nettype wire

>>> hw/rtl/swerve_module_kinematics.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swerve drive inverse kinematics
// Turns one chassis command into a heading and a speed for each wheel pod.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  ------    ---------  -------------------------  ------------------------------
//  in        input      i_in_valid / o_in_ready    vel_x, vel_y, rot_power
//  out       output     o_out_valid / i_out_ready  pod_index, steer_angle,
//                                                  wheel_speed, last_pod
//  cfg       input      i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// STEPS = min(CORDIC_STEPS, 24) is the length of the cell chain. Each pod vector
// rides the chain alone: the next pod is launched only once the previous result
// beat has been taken, so a stalled output stretches the command.
// The input is ready again as soon as the last pod has entered the chain.
// Reset is synchronous and clears the pod positions to zero; no clearing pass.
//
// The front end saves the command, sums the pod positions and divides by the
// pod count (reciprocal multiply) to find the centroid. Per pod it forms the
// offset, multiplies it by the rotation power (one shared multiplier), rounds
// to Q8.8 and saturates Vx = vel_x - dy*w and Vy = vel_y + dx*w.
// The vector is then folded into the right half plane and sent down a chain of
// CORDIC cells, one micro-rotation per cell per cycle. The output stage scales
// the magnitude by the inverse CORDIC gain, rounds the heading to 16 bits and
// holds the result beat in a register until it is taken.
// ----------------------------------------------------------------------------
module swerve_module_kinematics import swk_pkg::*; #(
    parameter int NUM_PODS     = NUM_PODS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [POS_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [POS_W-1:0] i_vel_x,
    input  wire logic signed [POS_W-1:0] i_vel_y,
    input  wire logic signed [POS_W-1:0] i_rot_power,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [POD_W-1:0]             o_pod_index,
    output logic [15:0]                  o_steer_angle,
    output logic [15:0]                  o_wheel_speed,
    output logic                         o_last_pod
);

    localparam int STEPS = (CORDIC_STEPS < TABLE_STEPS) ? CORDIC_STEPS : TABLE_STEPS;

    // w_chain[0] is the launch register of the front end; w_chain[STEPS] is
    // the last cell's output.
    t_cell_beat w_chain [STEPS+1];
    logic       w_done;

    swk_front #(
        .NUM_PODS (NUM_PODS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_rot_power (i_rot_power),
        .i_done      (w_done),
        .o_beat      (w_chain[0])
    );

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        swk_cordic_cell #(
            .SHIFT (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_beat  (w_chain[k]),
            .o_beat  (w_chain[k+1])
        );
    end

    swk_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_beat        (w_chain[STEPS]),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_pod_index   (o_pod_index),
        .o_steer_angle (o_steer_angle),
        .o_wheel_speed (o_wheel_speed),
        .o_last_pod    (o_last_pod),
        .o_done        (w_done)
    );

endmodule
`default_nettype wire

>>> hw/rtl/swk_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swerve kinematics front end
// Holds the pod positions, forms the centroid and per-pod wheel vectors and
// launches one vector at a time into the CORDIC cell chain.
// ----------------------------------------------------------------------------
module swk_front import swk_pkg::*; #(
    parameter int NUM_PODS = NUM_PODS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [POS_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic signed [POS_W-1:0] i_vel_x,
    input  wire logic signed [POS_W-1:0] i_vel_y,
    input  wire logic signed [POS_W-1:0] i_rot_power,
    input  wire logic                    i_done,
    output t_cell_beat                   o_beat
);

    localparam int SUM_W   = POS_W + $clog2(NUM_PODS);
    localparam int DIV_K   = 20;
    localparam logic [DIV_K-1:0] RECIP = DIV_K'(((1 << DIV_K) + NUM_PODS - 1) / NUM_PODS);
    localparam int OFF_W   = POS_W + 1;
    localparam int PROD_W  = OFF_W + POS_W;
    localparam int RND_W   = PROD_W + 1 - 8;
    localparam int DIFF_W  = RND_W + 1;
    localparam logic [POD_W-1:0] LAST_POD = POD_W'(NUM_PODS - 1);
    localparam logic signed [DIFF_W-1:0] SAT_HI = DIFF_W'(32767);
    localparam logic signed [DIFF_W-1:0] SAT_LO = -DIFF_W'(32768);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SUM    = 3'd1;
    localparam logic [2:0] S_CX     = 3'd2;
    localparam logic [2:0] S_CY     = 3'd3;
    localparam logic [2:0] S_MULX   = 3'd4;
    localparam logic [2:0] S_MULY   = 3'd5;
    localparam logic [2:0] S_SAT    = 3'd6;
    localparam logic [2:0] S_LAUNCH = 3'd7;

    logic [2:0]               r_state, n_state;
    logic signed [POS_W-1:0]  r_pos_x [4];
    logic signed [POS_W-1:0]  r_pos_y [4];
    logic signed [POS_W-1:0]  r_vel_x, r_vel_y, r_w;
    logic signed [SUM_W-1:0]  r_sum_x, r_sum_y;
    logic signed [POS_W-1:0]  r_cx, r_cy;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RND_W-1:0]  r_tx;
    logic signed [POS_W-1:0]  r_vx, r_vy;
    logic [POD_W-1:0]         r_pod;
    logic                     r_inflight;
    t_cell_beat               r_beat;

    logic signed [SUM_W-1:0]  sum_x, sum_y, div_in;
    logic [SUM_W-1:0]         div_abs;
    logic [SUM_W+DIV_K-1:0]   div_prod;
    logic signed [POS_W-1:0]  cent;
    logic signed [OFF_W-1:0]  off_x, off_y, mul_a;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [DIFF_W-1:0] diff_x, sum_vy;
    logic signed [XY_W-1:0]   x0, y0;
    logic                     launch, accept;

    function automatic logic signed [RND_W-1:0] f_round(input logic signed [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = (PROD_W+1)'(p) + (PROD_W+1)'(128);
        return t[PROD_W:8];
    endfunction

    function automatic logic signed [POS_W-1:0] f_sat(input logic signed [DIFF_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > SAT_HI) begin
            r = 16'sh7FFF;
        end else if (v < SAT_LO) begin
            r = -16'sh8000;
        end else begin
            r = POS_W'(v);
        end
        return r;
    endfunction

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign launch     = (r_state == S_LAUNCH) && !r_inflight;
    assign o_beat     = r_beat;

    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int p = 0; p < NUM_PODS; p++) begin
            sum_x = sum_x + SUM_W'(r_pos_x[p]);
            sum_y = sum_y + SUM_W'(r_pos_y[p]);
        end
    end

    // Centroid: truncating divide by the pod count as a reciprocal multiply
    // on the magnitude; exact for every sum the positions can give.
    always_comb begin
        div_in   = (r_state == S_CX) ? r_sum_x : r_sum_y;
        div_abs  = div_in[SUM_W-1] ? SUM_W'(-div_in) : SUM_W'(div_in);
        div_prod = (SUM_W+DIV_K)'(div_abs) * (SUM_W+DIV_K)'(RECIP);
        cent     = div_in[SUM_W-1] ? -POS_W'(div_prod[SUM_W+DIV_K-1:DIV_K])
                                   :  POS_W'(div_prod[SUM_W+DIV_K-1:DIV_K]);
    end

    always_comb begin
        off_x  = OFF_W'(r_pos_x[r_pod]) - OFF_W'(r_cx);
        off_y  = OFF_W'(r_pos_y[r_pod]) - OFF_W'(r_cy);
        mul_a  = (r_state == S_MULX) ? off_y : off_x;
        mul_p  = PROD_W'(mul_a) * PROD_W'(r_w);
        diff_x = DIFF_W'(r_vel_x) - DIFF_W'(r_tx);
        sum_vy = DIFF_W'(r_vel_y) + DIFF_W'(f_round(r_prod));
        x0     = XY_W'(r_vx) <<< GUARD_BITS;
        y0     = XY_W'(r_vy) <<< GUARD_BITS;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) begin n_state = S_SUM; end
            S_SUM:    n_state = S_CX;
            S_CX:     n_state = S_CY;
            S_CY:     n_state = S_MULX;
            S_MULX:   n_state = S_MULY;
            S_MULY:   n_state = S_SAT;
            S_SAT:    n_state = S_LAUNCH;
            S_LAUNCH: begin
                if (launch) begin
                    n_state = (r_pod == LAST_POD) ? S_IDLE : S_MULX;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_inflight <= 1'b0;
            r_beat.valid <= 1'b0;
            r_pod      <= '0;
            for (int p = 0; p < 4; p++) begin
                r_pos_x[p] <= '0;
                r_pos_y[p] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_beat.valid <= launch;
            if (launch) begin
                r_inflight <= 1'b1;
            end else if (i_done) begin
                r_inflight <= 1'b0;
            end
            if (launch) begin
                // Fold the left half plane onto the right one, starting half a turn away.
                r_beat.zero <= (r_vx == '0) && (r_vy == '0);
                r_beat.last <= (r_pod == LAST_POD);
                r_beat.pod  <= r_pod;
                r_beat.x    <= r_vx[POS_W-1] ? -x0 : x0;
                r_beat.y    <= r_vx[POS_W-1] ? -y0 : y0;
                r_beat.z    <= r_vx[POS_W-1] ? HALF_TURN : '0;
            end
            if (i_cfg_we) begin
                if (i_cfg_index[0] == AXIS_Y) begin
                    r_pos_y[i_cfg_index[CFG_IDX_W-1:1]] <= i_cfg_data;
                end else begin
                    r_pos_x[i_cfg_index[CFG_IDX_W-1:1]] <= i_cfg_data;
                end
            end
            if (r_state == S_CY) begin
                r_pod <= '0;
            end else if (launch) begin
                r_pod <= r_pod + POD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_vel_x <= i_vel_x;
            r_vel_y <= i_vel_y;
            r_w     <= i_rot_power;
        end
        if (r_state == S_SUM) begin
            r_sum_x <= sum_x;
            r_sum_y <= sum_y;
        end
        if (r_state == S_CX) begin
            r_cx <= cent;
        end
        if (r_state == S_CY) begin
            r_cy <= cent;
        end
        if (r_state == S_MULX) begin
            r_prod <= mul_p;
        end
        if (r_state == S_MULY) begin
            r_tx   <= f_round(r_prod);
            r_prod <= mul_p;
        end
        if (r_state == S_SAT) begin
            r_vx <= f_sat(diff_x);
            r_vy <= f_sat(sum_vy);
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/swk_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swerve kinematics CORDIC cell
// One vectoring micro-rotation with a fixed shift; registers its result
// for the next cell of the chain.
// ----------------------------------------------------------------------------
module swk_cordic_cell import swk_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_beat i_beat,
    output t_cell_beat      o_beat
);

    logic signed [XY_W-1:0] x_in, y_in, xs, ys;
    t_cell_beat             r_beat;

    assign x_in   = i_beat.x;
    assign y_in   = i_beat.y;
    assign xs     = x_in >>> SHIFT;
    assign ys     = y_in >>> SHIFT;
    assign o_beat = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= i_beat.valid;
        end
        r_beat.zero <= i_beat.zero;
        r_beat.last <= i_beat.last;
        r_beat.pod  <= i_beat.pod;
        if (!y_in[XY_W-1]) begin
            r_beat.x <= x_in + ys;
            r_beat.y <= y_in - xs;
            r_beat.z <= i_beat.z + ATAN_TAB[SHIFT];
        end else begin
            r_beat.x <= x_in - ys;
            r_beat.y <= y_in + xs;
            r_beat.z <= i_beat.z - ATAN_TAB[SHIFT];
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/swk_post.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swerve kinematics output stage
// Removes the CORDIC gain, rounds the heading and holds the result beat
// until the consumer takes it.
// ----------------------------------------------------------------------------
module swk_post import swk_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cell_beat  i_beat,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [POD_W-1:0] o_pod_index,
    output logic [15:0]      o_steer_angle,
    output logic [15:0]      o_wheel_speed,
    output logic             o_last_pod,
    output logic             o_done
);

    localparam int XU_W   = XY_W - 1;
    localparam int PROD_W = XU_W + 32;
    localparam logic [PROD_W:0] MAG_HALF = (PROD_W+1)'(1) << (MAG_SHIFT - 1);

    logic [XU_W-1:0]   x_clamp;
    logic [ANG_W-1:0]  ang_rnd;
    logic [PROD_W:0]   mag_rnd;
    logic [PROD_W-MAG_SHIFT:0] mag_full;

    logic              r_a_valid, r_a_zero, r_a_last;
    logic [POD_W-1:0]  r_a_pod;
    logic [PROD_W-1:0] r_a_prod;
    logic [15:0]       r_a_angle;
    logic              r_out_valid;
    logic [POD_W-1:0]  r_pod;
    logic [15:0]       r_angle, r_speed;
    logic              r_last;

    assign x_clamp  = i_beat.x[XY_W-1] ? '0 : i_beat.x[XU_W-1:0];
    assign ang_rnd  = i_beat.z + ANG_W'(32'h8000);
    assign mag_rnd  = (PROD_W+1)'(r_a_prod) + MAG_HALF;
    assign mag_full = mag_rnd[PROD_W:MAG_SHIFT];

    assign o_out_valid   = r_out_valid;
    assign o_pod_index   = r_pod;
    assign o_steer_angle = r_angle;
    assign o_wheel_speed = r_speed;
    assign o_last_pod    = r_last;
    assign o_done        = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid <= i_beat.valid;
            if (r_a_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat.valid) begin
            r_a_prod  <= PROD_W'(x_clamp) * PROD_W'(INV_GAIN);
            r_a_angle <= ang_rnd[ANG_W-1:ANG_W-16];
            r_a_zero  <= i_beat.zero;
            r_a_pod   <= i_beat.pod;
            r_a_last  <= i_beat.last;
        end
        if (r_a_valid) begin
            r_pod  <= r_a_pod;
            r_last <= r_a_last;
            if (r_a_zero) begin
                r_angle <= '0;
                r_speed <= '0;
            end else begin
                r_angle <= r_a_angle;
                r_speed <= (mag_full[PROD_W-MAG_SHIFT:16] != '0) ? 16'hFFFF
                                                                 : mag_full[15:0];
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/swk_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Swerve kinematics port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module swk_checker import swk_pkg::*; #(
    parameter int NUM_PODS = NUM_PODS_DEF
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire logic [POD_W-1:0] o_pod_index,
    input wire logic [15:0]      o_steer_angle,
    input wire logic [15:0]      o_wheel_speed,
    input wire logic             o_last_pod
);

    localparam logic [POD_W-1:0] LAST_POD = POD_W'(NUM_PODS - 1);

    // A result beat waits until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    // A waiting result beat does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_pod_index) && $stable(o_steer_angle)
            && $stable(o_wheel_speed) && $stable(o_last_pod))
        else $error("result beat changed while stalled");

    // The last-pod mark sits exactly on the final pod.
    a_last_pod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last_pod == (o_pod_index == LAST_POD)))
        else $error("last-pod mark on the wrong pod");

    // Input ready drops once a command beat is taken.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after a command beat");

endmodule

bind swerve_module_kinematics swk_checker #(
    .NUM_PODS (NUM_PODS)
) u_swk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pod_index   (o_pod_index),
    .o_steer_angle (o_steer_angle),
    .o_wheel_speed (o_wheel_speed),
    .o_last_pod    (o_last_pod)
);
`default_nettype wire
